>>> sv/opt_pkg.sv
// shared types and constants for the owner permission table
package opt_pkg;

  localparam int TableDepth   = 16;
  localparam int HighestClass = 7;
  localparam int QueueDepth   = 2;

  localparam int OwnerW = 32;
  localparam int ClassW = 4;
  localparam int MaskW  = 4;
  localparam int ModeW  = 4;
  localparam int PolW   = 2;

  localparam int IdxW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW   = $clog2(TableDepth + 1);
  localparam int QPtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW  = $clog2(QueueDepth + 1);

  localparam logic [ModeW-1:0] ModeReset = ModeW'(1);
  localparam logic [ModeW-1:0] ModeFirst = ModeW'(1);
  localparam logic [ModeW-1:0] ModeLast  = ModeW'(4);

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_RESOLVE  = 1'b1
  } op_t;

  // classified word passed from the front to the back
  typedef struct packed {
    op_t               op;
    logic [OwnerW-1:0] owner;
    logic [ClassW-1:0] cls;
    logic [MaskW-1:0]  modes;
    logic              ok;
    logic [PolW-1:0]   pol;
  } item_t;

  typedef struct packed {
    logic [OwnerW-1:0] owner;
    logic [ClassW-1:0] cls;
    logic [MaskW-1:0]  modes;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE
  } bk_state_t;

endpackage

>>> sv/opt_front.sv
// front end: mode register, input acceptance and classification
module opt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [opt_pkg::ModeW-1:0]     cfg_active_mode,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [opt_pkg::OwnerW-1:0]    in_owner_id,
  input  logic [opt_pkg::ClassW-1:0]    in_mutation_class,
  input  logic [opt_pkg::MaskW-1:0]     in_permitted_modes,
  input  logic                          q_full,
  output logic                          q_push,
  output opt_pkg::item_t                q_item
);

  logic [opt_pkg::ModeW-1:0] mode_r;
  logic                      mode_ok;
  logic                      key_ok;
  logic                      mask_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= opt_pkg::ModeReset;
    end else if (cfg_valid) begin
      mode_r <= cfg_active_mode;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    mode_ok = (mode_r >= opt_pkg::ModeFirst) && (mode_r <= opt_pkg::ModeLast);
    key_ok  = (in_owner_id != '0) &&
              (in_mutation_class <= opt_pkg::ClassW'(opt_pkg::HighestClass));
    // a resolve ignores the mask field
    mask_ok = (opt_pkg::op_t'(in_operation) == opt_pkg::OP_RESOLVE) ||
              (in_permitted_modes != '0);
    q_item.op    = opt_pkg::op_t'(in_operation);
    q_item.owner = in_owner_id;
    q_item.cls   = in_mutation_class;
    q_item.modes = in_permitted_modes;
    q_item.ok    = mode_ok && key_ok && mask_ok;
    q_item.pol   = opt_pkg::PolW'(mode_r - opt_pkg::ModeFirst);
  end

endmodule

>>> sv/opt_queue.sv
// short queue of classified words between front and back
module opt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  opt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output opt_pkg::item_t pop_item,
  output logic           empty
);

  opt_pkg::item_t                  slot_r [opt_pkg::QueueDepth];
  logic [opt_pkg::QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [opt_pkg::QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [opt_pkg::QCntW-1:0]       cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full     = (cnt_r == opt_pkg::QCntW'(opt_pkg::QueueDepth));
  assign empty    = (cnt_r == '0);
  assign pop_item = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == opt_pkg::QPtrW'(opt_pkg::QueueDepth - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == opt_pkg::QPtrW'(opt_pkg::QueueDepth - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/opt_back.sv
// back end: table memory, key scan, decision and output register
module opt_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  opt_pkg::item_t          q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_accepted,
  output logic [opt_pkg::PolW-1:0] out_policy
);

  opt_pkg::entry_t                mem [opt_pkg::TableDepth];
  opt_pkg::entry_t                rd_data_r;
  opt_pkg::entry_t                wr_data;
  logic                           we;

  opt_pkg::bk_state_t             st_r, st_nxt;
  opt_pkg::item_t                 itm_r, itm_nxt;
  logic [opt_pkg::CntW-1:0]       idx_r, idx_nxt;
  logic [opt_pkg::CntW-1:0]       cnt_r, cnt_nxt;
  logic                           cmp_vld_r, cmp_vld_nxt;
  logic                           hit_r, hit_nxt;
  logic [opt_pkg::MaskW-1:0]      hmodes_r, hmodes_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_acc_r, out_acc_nxt;
  logic [opt_pkg::PolW-1:0]       out_pol_r, out_pol_nxt;
  logic                           out_free;
  logic                           acc;

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_policy   = out_pol_r;
  assign out_free     = !out_valid_r || !out_stall;

  always_comb begin
    st_nxt        = st_r;
    itm_nxt       = itm_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    cmp_vld_nxt   = cmp_vld_r;
    hit_nxt       = hit_r;
    hmodes_nxt    = hmodes_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_pol_nxt   = out_pol_r;
    q_pop         = 1'b0;
    we            = 1'b0;
    wr_data.owner = itm_r.owner;
    wr_data.cls   = itm_r.cls;
    wr_data.modes = itm_r.modes;

    if (itm_r.op == opt_pkg::OP_REGISTER) begin
      acc = itm_r.ok && !hit_r && (cnt_r < opt_pkg::CntW'(opt_pkg::TableDepth));
    end else begin
      acc = itm_r.ok && hit_r && hmodes_r[itm_r.pol];
    end

    unique case (st_r)
      opt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          itm_nxt     = q_item;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          hit_nxt     = 1'b0;
          st_nxt      = (q_item.ok && cnt_r != '0) ? opt_pkg::BK_SCAN :
                        opt_pkg::BK_DECIDE;
        end
      end
      opt_pkg::BK_SCAN: begin
        // read data is registered and arrives in the cycle after its address
        if (cmp_vld_r && rd_data_r.owner == itm_r.owner &&
            rd_data_r.cls == itm_r.cls) begin
          hit_nxt    = 1'b1;
          hmodes_nxt = rd_data_r.modes;
        end
        if (idx_r < cnt_r) begin
          idx_nxt     = idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            st_nxt = opt_pkg::BK_DECIDE;
          end
        end
      end
      opt_pkg::BK_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc;
          out_pol_nxt   = (acc && itm_r.op == opt_pkg::OP_RESOLVE) ? itm_r.pol : '0;
          if (acc && itm_r.op == opt_pkg::OP_REGISTER) begin
            we      = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          st_nxt = opt_pkg::BK_IDLE;
        end
      end
      default: begin
        st_nxt = opt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= opt_pkg::BK_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    itm_r     <= itm_nxt;
    idx_r     <= idx_nxt;
    hit_r     <= hit_nxt;
    hmodes_r  <= hmodes_nxt;
    out_acc_r <= out_acc_nxt;
    out_pol_r <= out_pol_nxt;
  end

  // entries at or above the fill count never take part in a match
  always_ff @(posedge clk) begin
    if (we) begin
      mem[cnt_r[opt_pkg::IdxW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[idx_r[opt_pkg::IdxW-1:0]];
  end

endmodule

>>> sv/owner_permission_table.sv
// owner permission table: one item at a time, scan of the filled entries per item
// path from input accept to out_valid: queue, IDLE pop, SCAN of the n entries stored
// (1..16), DECIDE and output register; no SCAN when the table is empty or the word
// fails the front checks; a new word is popped only once DECIDE has passed its result on
// the queue holds two classified words, so the front accepts up to two during a scan
// reset (synchronous, rst_n low): table empty, active mode 1, queue and output empty
module owner_permission_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [opt_pkg::ModeW-1:0]      cfg_active_mode,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [opt_pkg::OwnerW-1:0]     in_owner_id,
  input  logic [opt_pkg::ClassW-1:0]     in_mutation_class,
  input  logic [opt_pkg::MaskW-1:0]      in_permitted_modes,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic [opt_pkg::PolW-1:0]       out_policy
);

  logic           q_full, q_push, q_pop, q_empty;
  opt_pkg::item_t push_item, pop_item;

  opt_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_mode    (cfg_active_mode),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_owner_id        (in_owner_id),
    .in_mutation_class  (in_mutation_class),
    .in_permitted_modes (in_permitted_modes),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (push_item)
  );

  opt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  opt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_accepted (out_accepted),
    .out_policy   (out_policy)
  );

endmodule

>>> dv/owner_permission_table_tb.sv
// testbench for the owner permission table: random and directed words checked against a predictor
`timescale 1ns / 1ps

module owner_permission_table_tb;
  import opt_pkg::*;

  localparam int PoolSize = 24;
  localparam int Phases = 13;
  localparam int WordsPerPhase = 150;

  typedef struct packed {
    logic            accepted;
    logic [PolW-1:0] policy;
  } verdict_t;

  // keeps its own copy of the table and mode, queues one verdict per accepted word
  class permission_scoreboard;
    logic [OwnerW-1:0] owners[TableDepth];
    logic [ClassW-1:0] classes[TableDepth];
    logic [MaskW-1:0]  masks[TableDepth];
    int unsigned       filled;
    logic [ModeW-1:0]  mode;
    verdict_t          verdict_q[$];
    int unsigned       errors;
    int unsigned       words_in;
    int unsigned       results;
    int unsigned       granted;

    function new();
      filled = 0;
      mode = ModeReset;
      errors = 0;
      words_in = 0;
      results = 0;
      granted = 0;
      for (int i = 0; i < TableDepth; i++) begin
        owners[i] = '0;
        classes[i] = '0;
        masks[i] = '0;
      end
    endfunction

    function void set_mode(logic [ModeW-1:0] m);
      mode = m;
    endfunction

    function int find_slot(logic [OwnerW-1:0] owner, logic [ClassW-1:0] cls);
      for (int i = 0; i < filled; i++)
        if (owners[i] == owner && classes[i] == cls) return i;
      return -1;
    endfunction

    function void note_input(op_t op, logic [OwnerW-1:0] owner, logic [ClassW-1:0] cls,
                             logic [MaskW-1:0] modes);
      verdict_t v;
      int slot;
      v = '0;
      words_in++;
      if (mode >= ModeFirst && mode <= ModeLast && owner != '0 && cls <= HighestClass) begin
        slot = find_slot(owner, cls);
        if (op == OP_REGISTER) begin
          if (modes != '0 && filled < TableDepth && slot < 0) begin
            owners[filled] = owner;
            classes[filled] = cls;
            masks[filled] = modes;
            filled++;
            v.accepted = 1'b1;
          end
        end else if (slot >= 0 && masks[slot][mode - 1] == 1'b1) begin
          v.accepted = 1'b1;
          v.policy = PolW'(mode - 1);
        end
      end
      verdict_q.push_back(v);
    endfunction

    function void check_result(logic accepted, logic [PolW-1:0] policy);
      verdict_t v;
      results++;
      if (verdict_q.size() == 0) begin
        $error("result word with nothing expected: accepted %0d policy %0d", accepted, policy);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (accepted) granted++;
      if (accepted !== v.accepted) begin
        $error("accepted mismatch: expected %0d, actual %0d", v.accepted, accepted);
        errors++;
      end
      if (policy !== v.policy) begin
        $error("policy mismatch: expected %0d, actual %0d", v.policy, policy);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [ModeW-1:0] cfg_active_mode;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  logic [OwnerW-1:0] in_owner_id;
  logic [ClassW-1:0] in_mutation_class;
  logic [MaskW-1:0] in_permitted_modes;
  logic out_valid;
  logic out_stall;
  logic out_accepted;
  logic [PolW-1:0] out_policy;

  permission_scoreboard sb = new();
  int in_gap_max = 3;
  int out_gap_max = 3;
  logic [OwnerW-1:0] owner_pool[PoolSize];
  logic [ClassW-1:0] class_pool[PoolSize];

  always #2 clk = ~clk;

  owner_permission_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_mode    (cfg_active_mode),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_owner_id        (in_owner_id),
    .in_mutation_class  (in_mutation_class),
    .in_permitted_modes (in_permitted_modes),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_policy         (out_policy)
  );

  task automatic send_word(op_t op, logic [OwnerW-1:0] owner, logic [ClassW-1:0] cls,
                           logic [MaskW-1:0] modes);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_owner_id <= owner;
    in_mutation_class <= cls;
    in_permitted_modes <= modes;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, owner, cls, modes);
  endtask

  // mode changes only once every result is back
  task automatic reconfigure(logic [ModeW-1:0] m);
    in_valid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_active_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_mode(m);
  endtask

  task automatic random_words(int count);
    int pick;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, PoolSize - 1);
      if (r < 15)
        send_word(OP_REGISTER, owner_pool[pick], class_pool[pick],
                  ($urandom_range(0, 9) == 0) ? 4'h0 : MaskW'($urandom_range(1, 15)));
      else if (r < 80)
        send_word(OP_RESOLVE, owner_pool[pick], class_pool[pick], MaskW'($urandom()));
      else
        send_word(op_t'($urandom_range(0, 1)),
                  ($urandom_range(0, 1) == 1) ? '0 : OwnerW'($urandom()),
                  ClassW'($urandom_range(0, 15)), MaskW'($urandom()));
    end
  endtask

  // result side: a random stall, sometimes none, before each word
  initial begin
    int gap;
    out_stall = 1'b0;
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_accepted, out_policy);

  initial begin
    logic [ModeW-1:0] phase_mode[Phases];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_active_mode = '0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_owner_id = '0;
    in_mutation_class = '0;
    in_permitted_modes = '0;
    phase_mode = '{4'd1, 4'd3, 4'd4, 4'd2, 4'd0, 4'd15, 4'd4, 4'd3, 4'd2, 4'd1,
                   ModeW'($urandom_range(5, 14)), ModeW'($urandom_range(0, 15)), 4'd4};
    // pairs share an owner with different classes; owners 2 and 4 are overwritten afterwards
    for (int i = 0; i < PoolSize; i++) begin
      if (i % 2 == 1) begin
        owner_pool[i] = owner_pool[i - 1];
        class_pool[i] = ClassW'((class_pool[i - 1] + 1) % (HighestClass + 1));
      end else begin
        owner_pool[i] = OwnerW'($urandom_range(1, 32'hffff_ffff));
        class_pool[i] = ClassW'($urandom_range(0, HighestClass));
      end
    end
    owner_pool[2] = 32'h0000_0001;
    owner_pool[4] = 32'h8000_0000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, starting in the reset mode
    send_word(OP_RESOLVE, 32'hffff_ffff, 4'd7, 4'h0);
    send_word(OP_REGISTER, 32'h0, 4'd0, 4'hf);
    send_word(OP_REGISTER, 32'h1, 4'd8, 4'hf);
    send_word(OP_REGISTER, 32'h1, 4'd15, 4'hf);
    send_word(OP_REGISTER, 32'h1, 4'd0, 4'h0);
    send_word(OP_REGISTER, 32'hffff_ffff, 4'd7, 4'hf);
    send_word(OP_REGISTER, 32'hffff_ffff, 4'd7, 4'h1);
    send_word(OP_RESOLVE, 32'hffff_ffff, 4'd7, 4'hf);
    send_word(OP_REGISTER, 32'h1, 4'd0, 4'h2);
    send_word(OP_RESOLVE, 32'h1, 4'd0, 4'h0);
    send_word(OP_RESOLVE, 32'h1, 4'd1, 4'h0);
    send_word(OP_RESOLVE, 32'h0, 4'd0, 4'hf);
    send_word(OP_RESOLVE, 32'hffff_ffff, 4'd8, 4'hf);
    reconfigure(4'd2);
    send_word(OP_RESOLVE, 32'h1, 4'd0, 4'h0);
    send_word(OP_RESOLVE, 32'hffff_ffff, 4'd7, 4'h0);
    reconfigure(4'd0);
    send_word(OP_REGISTER, 32'h2, 4'd0, 4'hf);
    send_word(OP_RESOLVE, 32'h1, 4'd0, 4'h0);
    reconfigure(4'd15);
    send_word(OP_REGISTER, 32'h3, 4'd3, 4'hf);
    send_word(OP_RESOLVE, 32'hffff_ffff, 4'd7, 4'h0);
    reconfigure(4'd4);
    send_word(OP_RESOLVE, 32'hffff_ffff, 4'd7, 4'h0);
    send_word(OP_REGISTER, 32'h1, 4'd7, 4'h8);
    reconfigure(4'd3);
    send_word(OP_RESOLVE, 32'h1, 4'd7, 4'h0);
    send_word(OP_RESOLVE, 32'hffff_ffff, 4'd7, 4'h0);

    for (int p = 0; p < Phases; p++) begin
      reconfigure(phase_mode[p]);
      in_gap_max = (p % 3 == 0) ? 0 : 11;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      random_words(WordsPerPhase);
    end
    in_valid <= 1'b0;

    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.verdict_q.size());
      sb.errors++;
    end
    $display("run covered %0d words in, %0d results out, %0d granted, table %0d of %0d filled",
             sb.words_in, sb.results, sb.granted, sb.filled, TableDepth);
    $display("modes 0 to 4, 15 and random settings, with and without idling on both sides");
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
sv/opt_pkg.sv
sv/opt_front.sv
sv/opt_queue.sv
sv/opt_back.sv
sv/owner_permission_table.sv
dv/owner_permission_table_tb.sv
